// ===== rtl/sbr_pkg.sv =====
// shared types and codes for the sprite blitter
// no dependencies; imported by every other file of the block
package sbr_pkg;

   // operation codes carried in req_type
   typedef enum logic [2:0] {
      OP_LOAD_FRAME = 3'd0,
      OP_LOAD_BG    = 3'd1,
      OP_BLEND      = 3'd2,
      OP_REPLACE    = 3'd3,
      OP_ERASE      = 3'd4,
      OP_RESTORE    = 3'd5,
      OP_READ       = 3'd6
   } sbr_op_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_MODIFY
   } sbr_state_type;

   // buffer memory strobes
   typedef struct packed {
      logic rd_en;
      logic frame_we;
      logic bg_we;
   } sbr_mem_ctl_type;

   localparam int unsigned DATA_W = 8;
   localparam int unsigned COORD_W = 8;
   localparam int unsigned TYPE_W = 3;
   localparam int unsigned COL_W = 2;

endpackage

// ===== rtl/sbr_if.sv =====
// valid/ready channel interfaces for request and response items
// depends on sbr_pkg for field widths
interface sbr_req_if;
   import sbr_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [TYPE_W-1:0]    req_type;
   logic [COORD_W-1:0]   pos_x;
   logic [COORD_W-1:0]   pos_y;
   logic [COORD_W-1:0]   line_index;
   logic [COL_W-1:0]     byte_column;
   logic [DATA_W-1:0]    data_byte;

   modport source (output valid, req_type, pos_x, pos_y, line_index, byte_column,
                   data_byte, input ready);
   modport sink (input valid, req_type, pos_x, pos_y, line_index, byte_column,
                 data_byte, output ready);
endinterface

interface sbr_rsp_if;
   import sbr_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [DATA_W-1:0]    read_data;
   logic                 out_of_range;

   modport source (output valid, read_data, out_of_range, input ready);
   modport sink (input valid, read_data, out_of_range, output ready);
endinterface

// ===== rtl/sbr_addr_gen.sv =====
// byte address former: column + line * pitch, with the range check
// depends on sbr_pkg; result is registered on load
module sbr_addr_gen #(
   parameter int unsigned PITCH_BYTES = 32,
   parameter int unsigned DEPTH = 6144,
   parameter int unsigned ADDR_W = 17
) (
   input  logic                          clock,
   input  logic                          load,
   input  logic [sbr_pkg::COORD_W-1:0]   pos_x,
   input  logic [sbr_pkg::COORD_W-1:0]   pos_y,
   input  logic [sbr_pkg::COORD_W-1:0]   line_index,
   input  logic [sbr_pkg::COL_W-1:0]     byte_column,
   output logic [ADDR_W-1:0]             addr,
   output logic                          out_of_range
);
   import sbr_pkg::*;

   localparam int unsigned LINE_W = COORD_W + 1;

   logic [LINE_W-1:0] line_sum;
   logic [ADDR_W-1:0] addr_in;
   logic [ADDR_W-1:0] addr_ff;
   logic              oor_ff;

   assign line_sum = LINE_W'(pos_y) + LINE_W'(line_index);

   // constant multiply by the pitch, then the byte offsets
   assign addr_in = ADDR_W'(line_sum) * ADDR_W'(PITCH_BYTES)
                  + ADDR_W'(pos_x[COORD_W-1:2])
                  + ADDR_W'(byte_column);

   always_ff @(posedge clock) begin
      if (load) begin
         addr_ff <= addr_in;
         oor_ff  <= (addr_in >= ADDR_W'(DEPTH));
      end
   end

   assign addr = addr_ff;
   assign out_of_range = oor_ff;
endmodule

// ===== rtl/sbr_buffers.sv =====
// frame and background byte memories, with a registered read
// depends on sbr_pkg for the strobe struct
module sbr_buffers #(
   parameter int unsigned DEPTH = 6144,
   parameter int unsigned MEM_AW = 13
) (
   input  logic                          clock,
   input  sbr_pkg::sbr_mem_ctl_type      ctl,
   input  logic [MEM_AW-1:0]             addr,
   input  logic [sbr_pkg::DATA_W-1:0]    frame_wdata,
   input  logic [sbr_pkg::DATA_W-1:0]    bg_wdata,
   output logic [sbr_pkg::DATA_W-1:0]    frame_rdata,
   output logic [sbr_pkg::DATA_W-1:0]    bg_rdata
);
   import sbr_pkg::*;

   logic [DATA_W-1:0] frame_mem [DEPTH];
   logic [DATA_W-1:0] bg_mem [DEPTH];
   logic [DATA_W-1:0] frame_rd_ff;
   logic [DATA_W-1:0] bg_rd_ff;

   always_ff @(posedge clock) begin
      if (ctl.frame_we) begin
         frame_mem[addr] <= frame_wdata;
      end
      if (ctl.rd_en) begin
         frame_rd_ff <= frame_mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.bg_we) begin
         bg_mem[addr] <= bg_wdata;
      end
      if (ctl.rd_en) begin
         bg_rd_ff <= bg_mem[addr];
      end
   end

   assign frame_rdata = frame_rd_ff;
   assign bg_rdata = bg_rd_ff;
endmodule

// ===== rtl/sprite_blit_rmw_core.sv =====
// sprite blitter over a packed 2-bit-per-pixel frame buffer and a background buffer.
// Each request item names one byte, at (pos_x/4) + (pos_y+line_index)*PITCH_BYTES +
// byte_column, and an operation (load frame, load background, or-blend, replace,
// erase-restore, restore, read); one response item returns the frame byte after the
// operation, or out_of_range with zero data when the address lies past the buffer,
// in which case nothing is written. An item passes through address forming, the
// registered read of the buffer memories, then modify and write back; the frame
// read-modify-write sets this pace, so a new item is taken only once the last one
// has written back. The response register lets the next item be taken while a
// result still waits. Buffers hold no defined contents after reset and must be loaded.
// depends on sbr_pkg, sbr_if, sbr_addr_gen and sbr_buffers
module sprite_blit_rmw_core #(
   parameter int unsigned PITCH_BYTES = 32,
   parameter int unsigned LINES = 192
) (
   input  logic      clock,
   input  logic      reset,
   sbr_req_if.sink   req_in,
   sbr_rsp_if.source rsp_out
);
   import sbr_pkg::*;

   // buffer size and address widths
   localparam int unsigned DEPTH = PITCH_BYTES * LINES;
   localparam int unsigned MEM_AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   // largest address sum: two full coordinates, top byte column and offset
   localparam int unsigned SUM_MAX = 510 * PITCH_BYTES + 63 + 3;
   localparam int unsigned ADDR_TOP = (SUM_MAX > DEPTH) ? SUM_MAX : DEPTH;
   localparam int unsigned ADDR_W = $clog2(ADDR_TOP + 1);

   sbr_state_type      state_ff, state_in;
   logic [TYPE_W-1:0]  op_ff;
   logic [DATA_W-1:0]  data_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]  rsp_data_ff;
   logic               rsp_oor_ff;

   logic               accept;
   logic               slot_free;
   logic               finish;
   logic [ADDR_W-1:0]  addr;
   logic               oor;
   sbr_mem_ctl_type    mem_ctl;
   logic [DATA_W-1:0]  frame_rdata;
   logic [DATA_W-1:0]  bg_rdata;
   logic [DATA_W-1:0]  new_frame;
   logic               changes_frame;

   // address forming, registered on accept
   sbr_addr_gen #(
      .PITCH_BYTES (PITCH_BYTES),
      .DEPTH       (DEPTH),
      .ADDR_W      (ADDR_W)
   ) u_addr (
      .clock        (clock),
      .load         (accept),
      .pos_x        (req_in.pos_x),
      .pos_y        (req_in.pos_y),
      .line_index   (req_in.line_index),
      .byte_column  (req_in.byte_column),
      .addr         (addr),
      .out_of_range (oor)
   );

   sbr_buffers #(
      .DEPTH  (DEPTH),
      .MEM_AW (MEM_AW)
   ) u_buf (
      .clock       (clock),
      .ctl         (mem_ctl),
      .addr        (addr[MEM_AW-1:0]),
      .frame_wdata (new_frame),
      .bg_wdata    (data_ff),
      .frame_rdata (frame_rdata),
      .bg_rdata    (bg_rdata)
   );

   // one item at a time through the sequencer
   assign req_in.ready = (state_ff == ST_IDLE);
   assign accept = req_in.valid && req_in.ready;
   // response register free, or being emptied this cycle
   assign slot_free = !rsp_valid_ff || rsp_out.ready;
   assign finish = (state_ff == ST_MODIFY) && slot_free;

   // new frame byte from the read data and the item's data byte
   always_comb begin
      case (op_ff)
         OP_LOAD_FRAME, OP_REPLACE: new_frame = data_ff;
         OP_BLEND:                  new_frame = frame_rdata | data_ff;
         OP_ERASE:                  new_frame = (frame_rdata & ~data_ff) | bg_rdata;
         OP_RESTORE:                new_frame = bg_rdata;
         default:                   new_frame = frame_rdata;
      endcase
   end

   assign changes_frame = op_ff inside {OP_LOAD_FRAME, OP_REPLACE, OP_BLEND,
                                        OP_ERASE, OP_RESTORE};

   // sequencer: next state and memory strobes
   always_comb begin
      state_in = state_ff;
      mem_ctl = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            // out of range items skip the read
            mem_ctl.rd_en = !oor;
            state_in = ST_MODIFY;
         end
         ST_MODIFY: begin
            if (slot_free) begin
               mem_ctl.frame_we = !oor && changes_frame;
               mem_ctl.bg_we = !oor && (op_ff == OP_LOAD_BG);
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // item payload held while it is worked on
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_in.req_type;
         data_ff <= req_in.data_byte;
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_out.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (finish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_data_ff <= oor ? '0 : new_frame;
         rsp_oor_ff  <= oor;
      end
   end

   assign rsp_out.valid = rsp_valid_ff;
   assign rsp_out.read_data = rsp_data_ff;
   assign rsp_out.out_of_range = rsp_oor_ff;

   // a response only appears straight after a modify step
   a_rsp_after_modify: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_MODIFY))
      else $error("response raised without a modify step");

   // no write of either buffer for an address past the end
   a_no_write_oor: assert property (@(posedge clock) disable iff (reset)
      oor && (state_ff == ST_MODIFY) |-> !mem_ctl.frame_we && !mem_ctl.bg_we)
      else $error("buffer write for an out of range address");

   // at most one buffer written per item
   a_single_write: assert property (@(posedge clock) disable iff (reset)
      !(mem_ctl.frame_we && mem_ctl.bg_we))
      else $error("both buffers written at once");

   // writes happen only in the modify step
   a_write_in_modify: assert property (@(posedge clock) disable iff (reset)
      (mem_ctl.frame_we || mem_ctl.bg_we) |-> (state_ff == ST_MODIFY))
      else $error("buffer write outside the modify step");
endmodule

// ===== dv/sbr_blit_checker.sv =====
// response checker for the sprite blitter: watches both channels and predicts each result
// depends on sbr_pkg and sbr_if; instantiated beside the core by sprite_blit_rmw_core_tb
module sbr_blit_checker #(
   parameter int unsigned PITCH_BYTES = 32,
   parameter int unsigned LINES = 192
) (
   input  logic clock,
   input  logic reset,
   sbr_req_if   req_mon,
   sbr_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending
);
   import sbr_pkg::*;

   localparam int unsigned BUF_BYTES = PITCH_BYTES * LINES;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic              out_of_range;
   } frame_rsp_type;

   // shadow copies of the two buffers
   logic [DATA_W-1:0] frame_mem [BUF_BYTES];
   logic [DATA_W-1:0] bg_mem [BUF_BYTES];
   frame_rsp_type     expected_bytes [$];

   initial begin
      fail_count = 0;
      pending = 0;
   end

   function automatic frame_rsp_type blit_apply(input logic [TYPE_W-1:0] op,
                                                input logic [COORD_W-1:0] px, py, ln,
                                                input logic [COL_W-1:0] col,
                                                input logic [DATA_W-1:0] data);
      int unsigned       a;
      logic [DATA_W-1:0] fb;
      frame_rsp_type     res;
      a = int'(px >> 2) + (int'(py) + int'(ln)) * PITCH_BYTES + int'(col);
      if (a >= BUF_BYTES) begin
         res.read_data = '0;
         res.out_of_range = 1'b1;
         return res;
      end
      fb = frame_mem[a];
      case (op)
         OP_LOAD_FRAME, OP_REPLACE: fb = data;
         OP_LOAD_BG:                bg_mem[a] = data;
         OP_BLEND:                  fb = fb | data;
         OP_ERASE:                  fb = (fb & ~data) | bg_mem[a];
         OP_RESTORE:                fb = bg_mem[a];
         default:                   ;
      endcase
      frame_mem[a] = fb;
      res.read_data = fb;
      res.out_of_range = 1'b0;
      return res;
   endfunction

   task automatic log_mismatch(input string what, input frame_rsp_type want,
                               input frame_rsp_type got);
      fail_count++;
      if (fail_count <= 10)
         $display("%0t mismatch (%s): expected data %02h oor %b, got data %02h oor %b",
                  $time, what, want.read_data, want.out_of_range,
                  got.read_data, got.out_of_range);
   endtask

   // response side first, so an item taken on the same edge is never matched early
   always @(posedge clock) begin
      frame_rsp_type got;
      frame_rsp_type want;
      if (!reset) begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.read_data = rsp_mon.read_data;
            got.out_of_range = rsp_mon.out_of_range;
            if (expected_bytes.size() == 0) begin
               want = '0;
               log_mismatch("no item outstanding", want, got);
            end else begin
               want = expected_bytes.pop_front();
               if (got.read_data !== want.read_data || got.out_of_range !== want.out_of_range)
                  log_mismatch("field", want, got);
            end
         end
         if (req_mon.valid && req_mon.ready)
            expected_bytes.push_back(blit_apply(req_mon.req_type, req_mon.pos_x, req_mon.pos_y,
                                                req_mon.line_index, req_mon.byte_column,
                                                req_mon.data_byte));
      end
      pending = expected_bytes.size();
   end

endmodule

// ===== dv/sprite_blit_rmw_core_tb.sv =====
// top of the sprite blitter testbench: clock, reset, request and response stimulus, verdict
// depends on sbr_pkg, sbr_if, sprite_blit_rmw_core and sbr_blit_checker
module sprite_blit_rmw_core_tb;
   import sbr_pkg::*;

   localparam int unsigned PITCH_BYTES = 32;
   localparam int unsigned LINES = 192;
   localparam int unsigned BUF_BYTES = PITCH_BYTES * LINES;
   localparam int unsigned RANDOM_ITEMS = 1450;
   localparam int unsigned CALM_TAIL = 150;
   localparam int unsigned POOL_SIZE = 40;
   // the one request code with no named operation; the core treats it as a read
   localparam logic [TYPE_W-1:0] OP_SPARE = 3'd7;

   typedef struct {
      logic [TYPE_W-1:0]  op;
      logic [COORD_W-1:0] px;
      logic [COORD_W-1:0] py;
      logic [COORD_W-1:0] ln;
      logic [COL_W-1:0]   col;
      logic [DATA_W-1:0]  data;
   } blit_req_type;

   logic        clock;
   logic        reset;
   bit          idle_mode = 1'b1;
   int          fail_count;
   int          pending;
   int unsigned sent = 0;
   // which buffer bytes hold defined contents; nothing may read an unwritten byte
   bit          frame_ok [BUF_BYTES];
   bit          bg_ok [BUF_BYTES];
   // a handful of busy addresses so that most items land on bytes already loaded
   int unsigned hot_addr [POOL_SIZE];

   sbr_req_if req_ch();
   sbr_rsp_if rsp_ch();

   sprite_blit_rmw_core #(
      .PITCH_BYTES(PITCH_BYTES),
      .LINES(LINES)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_in(req_ch),
      .rsp_out(rsp_ch)
   );

   sbr_blit_checker #(
      .PITCH_BYTES(PITCH_BYTES),
      .LINES(LINES)
   ) blit_check (
      .clock(clock),
      .reset(reset),
      .req_mon(req_ch),
      .rsp_mon(rsp_ch),
      .fail_count(fail_count),
      .pending(pending)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // generous ceiling, well above the slowest legal run with every stall at its longest
   initial begin
      #2000000;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic int unsigned byte_addr(input blit_req_type r);
      return int'(r.px >> 2) + (int'(r.py) + int'(r.ln)) * PITCH_BYTES + int'(r.col);
   endfunction

   // mostly random bytes, with all-clear and all-set masks now and then
   function automatic logic [DATA_W-1:0] pick_byte();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hff;
         default: return DATA_W'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic blit_req_type mk(input logic [TYPE_W-1:0] op,
                                       input logic [COORD_W-1:0] px, py, ln,
                                       input logic [COL_W-1:0] col,
                                       input logic [DATA_W-1:0] data);
      blit_req_type r;
      r.op = op;
      r.px = px;
      r.py = py;
      r.ln = ln;
      r.col = col;
      r.data = data;
      return r;
   endfunction

   // split a byte address into random position fields that sum back to it
   function automatic blit_req_type aim_at(input int unsigned a);
      blit_req_type r;
      int unsigned  col_v, rest, px4, rows, lo, hi;
      col_v = $urandom_range(0, (a < 3) ? a : 3);
      rest = a - col_v;
      px4 = rest % PITCH_BYTES;
      // byte column past the pitch carries into the next line, which sets pos_x bit 7
      if ($urandom_range(0, 1) && px4 + PITCH_BYTES <= 63 && rest >= px4 + PITCH_BYTES)
         px4 += PITCH_BYTES;
      rows = (rest - px4) / PITCH_BYTES;
      lo = (rows > 255) ? rows - 255 : 0;
      hi = (rows < 255) ? rows : 255;
      r.py = COORD_W'($urandom_range(lo, hi));
      r.ln = COORD_W'(rows - r.py);
      r.px = COORD_W'((px4 << 2) | $urandom_range(0, 3));
      r.col = COL_W'(col_v);
      r.op = TYPE_W'($urandom_range(0, 7));
      r.data = pick_byte();
      return r;
   endfunction

   // swap an operation that would read an unloaded byte for one that is legal there,
   // then note what the item writes
   function automatic void settle_op(inout blit_req_type r);
      int unsigned a;
      bit          need_frame, need_bg;
      a = byte_addr(r);
      if (a >= BUF_BYTES)
         return;
      need_frame = r.op inside {OP_LOAD_BG, OP_BLEND, OP_ERASE, OP_READ, OP_SPARE};
      need_bg = r.op inside {OP_ERASE, OP_RESTORE};
      if ((need_frame && !frame_ok[a]) || (need_bg && !bg_ok[a])) begin
         if (!frame_ok[a] && !bg_ok[a]) begin
            case ($urandom_range(0, 1))
               0:       r.op = OP_LOAD_FRAME;
               default: r.op = OP_REPLACE;
            endcase
         end else if (!frame_ok[a]) begin
            case ($urandom_range(0, 2))
               0:       r.op = OP_LOAD_FRAME;
               1:       r.op = OP_REPLACE;
               default: r.op = OP_RESTORE;
            endcase
         end else begin
            case ($urandom_range(0, 5))
               0:       r.op = OP_LOAD_FRAME;
               1:       r.op = OP_LOAD_BG;
               2:       r.op = OP_BLEND;
               3:       r.op = OP_REPLACE;
               4:       r.op = OP_READ;
               default: r.op = OP_SPARE;
            endcase
         end
      end
      if (r.op inside {OP_LOAD_FRAME, OP_REPLACE, OP_RESTORE})
         frame_ok[a] = 1'b1;
      if (r.op == OP_LOAD_BG)
         bg_ok[a] = 1'b1;
   endfunction

   // present one item from a falling edge and hold it until the core takes it;
   // returns on the falling edge after acceptance so the next item can follow at once
   task automatic send(input blit_req_type r);
      int unsigned gap;
      settle_op(r);
      if (idle_mode && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 6);
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.req_type <= r.op;
      req_ch.pos_x <= r.px;
      req_ch.pos_y <= r.py;
      req_ch.line_index <= r.ln;
      req_ch.byte_column <= r.col;
      req_ch.data_byte <= r.data;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      sent++;
   endtask

   // response back-pressure: random stall bursts, none in the calm tail
   initial begin
      int unsigned hold;
      rsp_ch.ready = 1'b0;
      hold = 0;
      forever begin
         @(negedge clock);
         if (hold != 0) begin
            hold--;
            rsp_ch.ready <= 1'b0;
         end else if (idle_mode && !reset && $urandom_range(0, 4) == 0) begin
            hold = $urandom_range(0, 5);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin
      blit_req_type r;
      int unsigned  start, pick;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.req_type = OP_READ;
      req_ch.pos_x = '0;
      req_ch.pos_y = '0;
      req_ch.line_index = '0;
      req_ch.byte_column = '0;
      req_ch.data_byte = '0;
      hot_addr[0] = 0;
      hot_addr[1] = BUF_BYTES - 1;
      for (int i = 2; i < POOL_SIZE; i++)
         hot_addr[i] = $urandom_range(0, BUF_BYTES - 1);
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // directed: every operation on the first byte, starting from a known pattern
      send(mk(OP_LOAD_FRAME, 8'd0, 8'd0, 8'd0, 2'd0, 8'hff));
      send(mk(OP_LOAD_BG, 8'd0, 8'd0, 8'd0, 2'd0, 8'h0f));
      send(mk(OP_BLEND, 8'd0, 8'd0, 8'd0, 2'd0, 8'ha5));
      send(mk(OP_ERASE, 8'd0, 8'd0, 8'd0, 2'd0, 8'hf0));
      send(mk(OP_REPLACE, 8'd0, 8'd0, 8'd0, 2'd0, 8'h00));
      send(mk(OP_RESTORE, 8'd0, 8'd0, 8'd0, 2'd0, 8'h00));
      send(mk(OP_READ, 8'd0, 8'd0, 8'd0, 2'd0, 8'hff));
      // spare request code behaves as a read
      send(mk(OP_SPARE, 8'd0, 8'd0, 8'd0, 2'd0, 8'h3c));
      // last byte of the buffer: pos_x all ones, lines split between pos_y and line_index
      send(mk(OP_LOAD_FRAME, 8'd255, 8'd95, 8'd95, 2'd0, 8'h5a));
      send(mk(OP_LOAD_BG, 8'd255, 8'd95, 8'd95, 2'd0, 8'hc3));
      send(mk(OP_ERASE, 8'd255, 8'd95, 8'd95, 2'd0, 8'hff));
      send(mk(OP_READ, 8'd255, 8'd95, 8'd95, 2'd0, 8'h00));
      // byte column three is added as given
      send(mk(OP_LOAD_FRAME, 8'd0, 8'd0, 8'd0, 2'd3, 8'h81));
      send(mk(OP_BLEND, 8'd0, 8'd0, 8'd0, 2'd3, 8'h18));
      // column carry past the pitch into the next line
      send(mk(OP_LOAD_FRAME, 8'd252, 8'd0, 8'd0, 2'd3, 8'h42));
      send(mk(OP_BLEND, 8'd253, 8'd0, 8'd0, 2'd3, 8'h24));
      // past the buffer: every field at its maximum, then the first byte beyond the end
      send(mk(OP_BLEND, 8'd255, 8'd255, 8'd255, 2'd3, 8'hff));
      send(mk(OP_REPLACE, 8'd0, 8'd0, 8'd192, 2'd0, 8'h77));
      r = aim_at(BUF_BYTES);
      r.op = OP_LOAD_FRAME;
      send(r);
      // the refused write must leave the last byte as it was
      send(mk(OP_READ, 8'd255, 8'd190, 8'd0, 2'd0, 8'h00));

      // random part: mostly sprite traffic on busy bytes, some noise and edge addresses
      start = sent;
      while (sent - start < RANDOM_ITEMS) begin
         if (sent - start >= RANDOM_ITEMS - CALM_TAIL)
            idle_mode = 1'b0;
         pick = $urandom_range(0, 99);
         if (pick < 25) begin
            // one sprite line three bytes wide: blend it in, then erase it again
            r = aim_at(hot_addr[$urandom_range(0, POOL_SIZE - 1)]);
            for (int c = 0; c < 3; c++) begin
               r.col = COL_W'(c);
               r.op = OP_BLEND;
               r.data = pick_byte();
               send(r);
            end
            for (int c = 0; c < 3; c++) begin
               r.col = COL_W'(c);
               r.op = OP_ERASE;
               send(r);
            end
         end else if (pick < 75) begin
            send(aim_at(hot_addr[$urandom_range(0, POOL_SIZE - 1)]));
         end else if (pick < 88) begin
            // unconstrained fields; most of these fall past the buffer
            r.op = TYPE_W'($urandom_range(0, 7));
            r.px = COORD_W'($urandom_range(0, 255));
            r.py = COORD_W'($urandom_range(0, 255));
            r.ln = COORD_W'($urandom_range(0, 255));
            r.col = COL_W'($urandom_range(0, 3));
            r.data = pick_byte();
            send(r);
         end else begin
            // around the end of the buffer
            send(aim_at($urandom_range(BUF_BYTES - 4, BUF_BYTES + 3)));
         end
      end
      req_ch.valid <= 1'b0;

      // drain, then give the pipeline a few cycles to show any stray result
      wait (pending == 0);
      repeat (12) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/sbr_pkg.sv
rtl/sbr_if.sv
rtl/sbr_addr_gen.sv
rtl/sbr_buffers.sv
rtl/sprite_blit_rmw_core.sv
dv/sbr_blit_checker.sv
dv/sprite_blit_rmw_core_tb.sv
